// ----- design/u8d_pkg.sv -----
// shared types and constants for the six-byte utf-8 decoder
package u8d_pkg;

  localparam int unsigned CpWidth   = 31;
  localparam int unsigned PendWidth = 3;

  localparam logic [CpWidth-1:0] ReplacementChar = CpWidth'(32'h0000_FFFD);

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // open-sequence state carried from beat to beat
  typedef struct packed {
    logic [PendWidth-1:0] pend;
    logic [CpWidth-1:0]   acc;
    logic                 bad;
  } dec_state_t;

  // one decoded result
  typedef struct packed {
    logic               valid;
    logic [CpWidth-1:0] cp;
    logic               err;
  } dec_result_t;

  localparam dec_state_t IdleState = '{pend: '0, acc: '0, bad: 1'b0};

endpackage

// ----- design/utf8_six_byte_decoder_unit.sv -----
// utf-8 decoder for original sequences of one to six bytes
//
// Input channel: one encoded byte per beat on in_byte_i, with stream_end_i
// marking the final byte of the stream. A beat is taken when in_valid_i is
// high and in_stall_o is low.
// Output channel: zero or one result per input beat, code_point_o and
// status_o (0 ok, 1 malformed or truncated, code point then 0xFFFD). A beat
// is delivered when out_valid_o is high and out_stall_i is low.
// Throughput is one byte per cycle while the output is not stalled: the
// byte is registered, decoded against the sequence state, and the result
// goes into the result register. Lead and middle bytes of a
// sequence produce no beat, unless stream_end_i cuts the sequence short.
// When the receiver stalls, the result register holds and the input
// register fills; in_stall_o rises only when both are full and the output
// is stalled, so no beat is lost or repeated.
// Reset clears both registers' valid flags and closes any open sequence;
// the block is ready as soon as reset is released.
module utf8_six_byte_decoder_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  in_byte_i,
  input  logic                        stream_end_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [u8d_pkg::CpWidth-1:0] code_point_o,
  output logic                        status_o
);
  import u8d_pkg::*;

  logic                 s1_valid_q;
  logic [7:0]           s1_byte_q;
  logic                 s1_last_q;
  dec_state_t           st_q, st_d;
  dec_result_t          res_d;
  logic                 out_valid_q;
  logic [CpWidth-1:0]   out_cp_q;
  logic                 out_err_q;
  logic                 adv;
  logic                 in_take;

  // pipeline advance and handshake
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !adv;
  assign in_take    = in_valid_i && !in_stall_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_byte_q <= in_byte_i;
      s1_last_q <= stream_end_i;
    end
  end

  // decode
  u8d_step u_step (
    .state_i  (st_q),
    .byte_i   (s1_byte_q),
    .last_i   (s1_last_q),
    .state_o  (st_d),
    .result_o (res_d)
  );

  // sequence state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= IdleState;
    end else if (s1_valid_q && adv) begin
      st_q <= st_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s1_valid_q && res_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_valid_q && res_d.valid) begin
      out_cp_q  <= res_d.cp;
      out_err_q <= res_d.err;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign code_point_o = out_cp_q;
  assign status_o     = out_err_q;

  // checks
  a_pend_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.pend <= PendWidth'(5))
    else $error("pending count out of range");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.pend == '0) |-> (st_q.acc == '0 && !st_q.bad))
    else $error("idle state carries stale payload");

  a_err_cp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_err_q == STATUS_ERR) |-> (out_cp_q == ReplacementChar))
    else $error("error result without replacement character");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled while pipeline has room");

  a_hold_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s1_valid_q && adv) |=> $stable(st_q))
    else $error("sequence state moved without a byte");

endmodule

// ----- design/u8d_step.sv -----
// decode step: one byte against the open-sequence state
module u8d_step (
  input  u8d_pkg::dec_state_t  state_i,
  input  logic [7:0]           byte_i,
  input  logic                 last_i,
  output u8d_pkg::dec_state_t  state_o,
  output u8d_pkg::dec_result_t result_o
);
  import u8d_pkg::*;

  logic [PendWidth-1:0] lead_more;
  logic [5:0]           lead_payload;
  logic                 lead_ok;
  logic [PendWidth-1:0] pend_dec;
  logic [CpWidth-1:0]   acc_shift;
  logic                 bad_any;

  // lead byte classification
  always_comb begin
    lead_more    = '0;
    lead_payload = '0;
    lead_ok      = 1'b1;
    priority if (byte_i[7:5] == 3'b110) begin
      lead_more    = PendWidth'(1);
      lead_payload = {1'b0, byte_i[4:0]};
    end else if (byte_i[7:4] == 4'b1110) begin
      lead_more    = PendWidth'(2);
      lead_payload = {2'b00, byte_i[3:0]};
    end else if (byte_i[7:3] == 5'b11110) begin
      lead_more    = PendWidth'(3);
      lead_payload = {3'b000, byte_i[2:0]};
    end else if (byte_i[7:2] == 6'b111110) begin
      lead_more    = PendWidth'(4);
      lead_payload = {4'b0000, byte_i[1:0]};
    end else if (byte_i[7:1] == 7'b1111110) begin
      lead_more    = PendWidth'(5);
      lead_payload = {5'b00000, byte_i[0]};
    end else begin
      lead_ok = 1'b0;
    end
  end

  // continuation path
  assign pend_dec  = state_i.pend - PendWidth'(1);
  assign acc_shift = {state_i.acc[CpWidth-7:0], byte_i[5:0]};
  assign bad_any   = state_i.bad | (byte_i[7:6] != 2'b10);

  // next state and result
  always_comb begin
    state_o           = IdleState;
    result_o.valid    = 1'b0;
    result_o.cp       = ReplacementChar;
    result_o.err      = STATUS_ERR;
    if (state_i.pend == '0) begin
      priority if (!byte_i[7]) begin
        result_o.valid = 1'b1;
        result_o.cp    = CpWidth'(byte_i);
        result_o.err   = STATUS_OK;
      end else if (!lead_ok || byte_i[7:6] == 2'b10) begin
        result_o.valid = 1'b1;
      end else if (last_i) begin
        result_o.valid = 1'b1;
      end else begin
        state_o.pend = lead_more;
        state_o.acc  = CpWidth'(lead_payload);
        state_o.bad  = 1'b0;
      end
    end else begin
      priority if (pend_dec == '0) begin
        result_o.valid = 1'b1;
        result_o.err   = bad_any;
        result_o.cp    = bad_any ? ReplacementChar : acc_shift;
      end else if (last_i) begin
        result_o.valid = 1'b1;
      end else begin
        state_o.pend = pend_dec;
        state_o.acc  = acc_shift;
        state_o.bad  = bad_any;
      end
    end
  end

endmodule
